/* rtl/core/aoc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the alpha-over compositing pixel unit.
// Used by aoc_div_pipe and alpha_over_composite_pixel_unit; depends on nothing.
package aoc_pkg;

  // Pixel packing: red 7:0, green 15:8, blue 23:16, alpha 31:24.
  localparam int PIX_W  = 32;
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;

  // Blend arithmetic widths. The numerator never exceeds 25 bits and the
  // denominator 256*(as+ad) - as*ad never exceeds 16 bits.
  localparam int NUM_W     = 25;
  localparam int DEN_W     = 16;
  localparam int DIV_STEPS = CH_W;

  // Alpha remap arithmetic in Q4.12.
  localparam int CFG_W     = 16;
  localparam int DIFF_W    = CFG_W + 1;
  localparam int PROD_W    = DIFF_W + CH_W + 1;
  localparam int V_W       = PROD_W + 1;
  localparam int FRAC_W    = 12;
  localparam logic [V_W-1:0] ROUND_HALF = V_W'(2048);

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_END    = 2'd2;
  localparam logic [CFG_W-1:0]     ALPHA_END_RESET  = 16'd4096;

  // How the result pixel is formed.
  typedef enum logic [1:0] {
    MODE_BLEND  = 2'd0,
    MODE_TARGET = 2'd1,
    MODE_SOURCE = 2'd2
  } aoc_mode_t;

  // Sideband that travels with an item through the divider.
  typedef struct packed {
    aoc_mode_t          mode;
    logic [PIX_W-1:0]   pix;
    logic [CH_W-1:0]    alpha;
  } aoc_side_t;

endpackage

/* rtl/core/aoc_div_pipe.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: three channel lanes share one denominator,
// one quotient bit per stage. Depends on aoc_pkg.
module aoc_div_pipe
  import aoc_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [NUM_CH-1:0][NUM_W-1:0]     in_num,
  input  logic [DEN_W-1:0]                 in_den,
  input  aoc_side_t                        in_side,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [NUM_CH-1:0][CH_W-1:0]      out_quo,
  output aoc_side_t                        out_side
);

  // Per-stage registers.
  logic [DIV_STEPS-1:0]                 vld_r;
  logic [NUM_CH-1:0][NUM_W-1:0]         rem_r  [DIV_STEPS];
  logic [NUM_CH-1:0][CH_W-1:0]          quo_r  [DIV_STEPS];
  logic [DEN_W-1:0]                     den_r  [DIV_STEPS];
  aoc_side_t                            side_r [DIV_STEPS];

  // Stage inputs, taken from the ports or the previous stage.
  logic [DIV_STEPS-1:0]                 vin;
  logic [NUM_CH-1:0][NUM_W-1:0]         rem_in  [DIV_STEPS];
  logic [NUM_CH-1:0][CH_W-1:0]          quo_in  [DIV_STEPS];
  logic [DEN_W-1:0]                     den_in  [DIV_STEPS];
  aoc_side_t                            side_in [DIV_STEPS];

  // A stage may load when it is empty or its item moves on.
  logic [DIV_STEPS:0] adv;
  assign adv[DIV_STEPS] = out_ready;

  genvar k, l;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_stage
      localparam int B = DIV_STEPS - 1 - k;

      assign adv[k] = !vld_r[k] || adv[k+1];

      if (k == 0) begin : g_first
        assign vin[k]     = in_valid;
        assign rem_in[k]  = in_num;
        assign quo_in[k]  = '0;
        assign den_in[k]  = in_den;
        assign side_in[k] = in_side;
      end else begin : g_next
        assign vin[k]     = vld_r[k-1];
        assign rem_in[k]  = rem_r[k-1];
        assign quo_in[k]  = quo_r[k-1];
        assign den_in[k]  = den_r[k-1];
        assign side_in[k] = side_r[k-1];
      end

      // Valid bit of this stage.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (adv[k]) begin
          vld_r[k] <= vin[k];
        end
      end

      // Shared denominator and sideband.
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          den_r[k]  <= den_in[k];
          side_r[k] <= side_in[k];
        end
      end

      for (l = 0; l < NUM_CH; l++) begin : g_lane
        logic [NUM_W-1:0] dsh;
        logic             ge;

        // Compare against the denominator shifted to this quotient bit.
        assign dsh = {{(NUM_W-DEN_W){1'b0}}, den_in[k]} << B;
        assign ge  = rem_in[k][l] >= dsh;

        always_ff @(posedge clk) begin
          if (adv[k]) begin
            rem_r[k][l] <= ge ? (rem_in[k][l] - dsh) : rem_in[k][l];
            quo_r[k][l] <= quo_in[k][l] | (CH_W'(ge) << B);
          end
        end
      end
    end
  endgenerate

  assign in_ready  = adv[0];
  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_quo   = quo_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

/* rtl/core/alpha_over_composite_pixel_unit.sv */
`timescale 1ns / 1ps
// Alpha-over compositing of one source pixel onto one target pixel per item.
// The path from input accept to out_valid runs through four arithmetic stages,
// eight divider stages (one quotient bit each) and the output register.
// Throughput is one item per cycle; stages hold their item under out_stall and
// empty stages fill, so bubbles close up. Reset clears all valid bits and sets
// the registers to remap off, alpha_start 0 and alpha_end 4096.
// Depends on aoc_pkg and aoc_div_pipe.
module alpha_over_composite_pixel_unit
  import aoc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_source_pixel,
  input  logic [PIX_W-1:0]      in_target_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_result_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  // Configuration registers; writes are always taken.
  logic             remap_enable_r;
  logic [CFG_W-1:0] alpha_start_r;
  logic [CFG_W-1:0] alpha_end_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remap_enable_r <= 1'b0;
      alpha_start_r  <= '0;
      alpha_end_r    <= ALPHA_END_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REMAP_ENABLE: remap_enable_r <= cfg_data[0];
        CFG_ALPHA_START:  alpha_start_r  <= cfg_data;
        CFG_ALPHA_END:    alpha_end_r    <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Pipeline control: a stage loads when empty or when its item moves on.
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic adv1, adv2, adv3, adv4, adv_out, div_in_ready, div_out_valid;

  assign adv_out  = !vo_r || !out_stall;
  assign adv4     = !v4_r || div_in_ready;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv1)    v1_r <= in_valid;
      if (adv2)    v2_r <= v1_r;
      if (adv3)    v3_r <= v2_r;
      if (adv4)    v4_r <= v3_r;
      if (adv_out) vo_r <= div_out_valid;
    end
  end

  // Stage 1: linear alpha remap value start*255 + a*(end - start) in Q4.12.
  logic signed [DIFF_W-1:0] diff;
  logic signed [V_W-1:0]    start255;
  logic signed [PROD_W-1:0] remap_prod;
  logic signed [V_W-1:0]    v_nxt;
  logic signed [V_W-1:0]    v_r;
  logic [PIX_W-1:0]         src1_r, tgt1_r;

  always_comb begin
    diff       = DIFF_W'($signed(alpha_end_r)) - DIFF_W'($signed(alpha_start_r));
    start255   = (V_W'($signed(alpha_start_r)) <<< 8) - V_W'($signed(alpha_start_r));
    remap_prod = PROD_W'($signed({1'b0, in_source_pixel[PIX_W-1 -: CH_W]})) *
                 PROD_W'(diff);
    v_nxt      = start255 + V_W'(remap_prod);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      src1_r <= in_source_pixel;
      tgt1_r <= in_target_pixel;
      v_r    <= v_nxt;
    end
  end

  // Stage 2: clamp at zero, round half up, saturate, and replace the alpha when remap is enabled.
  logic [V_W-1:0]   v_rnd;
  logic [CH_W-1:0]  remap_alpha;
  logic [PIX_W-1:0] src2_r, tgt2_r;

  always_comb begin
    v_rnd = $unsigned(v_r) + ROUND_HALF;
    if (v_r[V_W-1]) begin
      remap_alpha = '0;
    end else if (|v_rnd[V_W-1:FRAC_W+CH_W]) begin
      remap_alpha = '1;
    end else begin
      remap_alpha = v_rnd[FRAC_W +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      src2_r <= remap_enable_r ? {remap_alpha, src1_r[PIX_W-CH_W-1:0]} : src1_r;
      tgt2_r <= tgt1_r;
    end
  end

  // Stage 3: pick the case and form the first products.
  logic [CH_W-1:0]                 as2, ad2;
  aoc_mode_t                       mode_nxt;
  logic [PIX_W-1:0]                pix_nxt;
  aoc_mode_t                       mode3_r;
  logic [PIX_W-1:0]                pix3_r;
  logic [CH_W-1:0]                 as3_r, ad3_r;
  logic [2*CH_W-1:0]               asad3_r;
  logic [NUM_CH-1:0][2*CH_W-1:0]   csas3_r, cdad3_r;

  always_comb begin
    as2 = src2_r[PIX_W-1 -: CH_W];
    ad2 = tgt2_r[PIX_W-1 -: CH_W];
    if (as2 == '0) begin
      mode_nxt = MODE_TARGET;
      pix_nxt  = tgt2_r;
    end else if (as2 == '1 || ad2 == '0) begin
      mode_nxt = MODE_SOURCE;
      pix_nxt  = src2_r;
    end else begin
      mode_nxt = MODE_BLEND;
      pix_nxt  = src2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      mode3_r <= mode_nxt;
      pix3_r  <= pix_nxt;
      as3_r   <= as2;
      ad3_r   <= ad2;
      asad3_r <= (2*CH_W)'(as2) * (2*CH_W)'(ad2);
      for (int c = 0; c < NUM_CH; c++) begin
        csas3_r[c] <= (2*CH_W)'(src2_r[c*CH_W +: CH_W]) * (2*CH_W)'(as2);
        cdad3_r[c] <= (2*CH_W)'(tgt2_r[c*CH_W +: CH_W]) * (2*CH_W)'(ad2);
      end
    end
  end

  // Stage 4: denominator, numerators and the blended alpha.
  logic [CH_W:0]                  inv_as;
  logic [DEN_W:0]                 den_full;
  logic [NUM_CH-1:0][NUM_W-1:0]   num4_r;
  logic [DEN_W-1:0]               den4_r;
  aoc_side_t                      side4_r;

  always_comb begin
    inv_as   = (CH_W+1)'(1 << CH_W) - {1'b0, as3_r};
    den_full = (((DEN_W+1)'(as3_r) + (DEN_W+1)'(ad3_r)) << CH_W) -
               (DEN_W+1)'(asad3_r);
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      den4_r        <= den_full[DEN_W-1:0];
      side4_r.mode  <= mode3_r;
      side4_r.pix   <= pix3_r;
      side4_r.alpha <= den_full[CH_W +: CH_W];
      for (int c = 0; c < NUM_CH; c++) begin
        num4_r[c] <= NUM_W'({csas3_r[c], {CH_W{1'b0}}}) +
                     NUM_W'(cdad3_r[c]) * NUM_W'(inv_as);
      end
    end
  end

  // Stages 5 to 12: per-channel division by the shared denominator.
  logic [NUM_CH-1:0][CH_W-1:0] div_quo;
  aoc_side_t                   div_side;

  aoc_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_ready  (div_in_ready),
    .in_num    (num4_r),
    .in_den    (den4_r),
    .in_side   (side4_r),
    .out_valid (div_out_valid),
    .out_ready (adv_out),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // Output register: blended pixel or one of the inputs passed through.
  logic [PIX_W-1:0] result_nxt;
  logic [PIX_W-1:0] result_r;

  always_comb begin
    case (div_side.mode)
      MODE_BLEND:  result_nxt = {div_side.alpha, div_quo[2], div_quo[1], div_quo[0]};
      MODE_TARGET: result_nxt = div_side.pix;
      MODE_SOURCE: result_nxt = div_side.pix;
      default:     result_nxt = div_side.pix;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = vo_r;
  assign out_result_pixel = result_r;

endmodule
